// File: hdl/t4p_pkg.sv
// Shared types, register map and axis-order table for the four-index reorder block.
`default_nettype none
package t4p_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned DEST_W = 16;
  localparam int unsigned EXT_REG_W = 5;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_EXTENT_A   = 3'd0;
  localparam reg_idx_t REG_EXTENT_B   = 3'd1;
  localparam reg_idx_t REG_EXTENT_C   = 3'd2;
  localparam reg_idx_t REG_EXTENT_D   = 3'd3;
  localparam reg_idx_t REG_SWAP_12    = 3'd4;
  localparam reg_idx_t REG_SWAP_34    = 3'd5;
  localparam reg_idx_t REG_SWAP_PAIRS = 3'd6;

  typedef logic [1:0] axis_t;
  localparam axis_t AX_A = 2'd0;
  localparam axis_t AX_B = 2'd1;
  localparam axis_t AX_C = 2'd2;
  localparam axis_t AX_D = 2'd3;

  // {swap_pairs, swap_12, swap_34}
  typedef logic [2:0] order_sel_t;
  localparam order_sel_t SEL_1243     = 3'd0;
  localparam order_sel_t SEL_1243_ALT = 3'd1;
  localparam order_sel_t SEL_2134     = 3'd2;
  localparam order_sel_t SEL_2143     = 3'd3;
  localparam order_sel_t SEL_3412     = 3'd4;
  localparam order_sel_t SEL_3421     = 3'd5;
  localparam order_sel_t SEL_4312     = 3'd6;
  localparam order_sel_t SEL_4321     = 3'd7;

  typedef logic [1:0] step_t;

  typedef struct packed {
    logic [EXT_REG_W-1:0] extent_a;
    logic [EXT_REG_W-1:0] extent_b;
    logic [EXT_REG_W-1:0] extent_c;
    logic [EXT_REG_W-1:0] extent_d;
    logic                 swap_12;
    logic                 swap_34;
    logic                 swap_pairs;
  } cfg_t;

  typedef struct packed {
    logic  load;
    logic  mac;
    logic  emit;
    step_t step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // Axis taken at a given step of the row-major fold, outermost first.
  function automatic axis_t order_axis(order_sel_t sel, step_t step);
    logic [7:0] seq;
    case (sel)
      SEL_1243, SEL_1243_ALT: seq = {AX_A, AX_B, AX_D, AX_C};
      SEL_2134: seq = {AX_B, AX_A, AX_C, AX_D};
      SEL_2143: seq = {AX_B, AX_A, AX_D, AX_C};
      SEL_3412: seq = {AX_C, AX_D, AX_A, AX_B};
      SEL_3421: seq = {AX_C, AX_D, AX_B, AX_A};
      SEL_4312: seq = {AX_D, AX_C, AX_A, AX_B};
      SEL_4321: seq = {AX_D, AX_C, AX_B, AX_A};
      default:  seq = {AX_A, AX_B, AX_D, AX_C};
    endcase
    return seq[(3 - step) * 2 +: 2];
  endfunction

endpackage
`default_nettype wire

// File: hdl/t4p_if.sv
// Valid/ready stream interfaces for source words and reordered result words.
`default_nettype none
interface t4p_in_if;
  import t4p_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

interface t4p_out_if;
  import t4p_pkg::*;
  logic              valid;
  logic              ready;
  logic [DEST_W-1:0] dest_index;
  logic [WORD_W-1:0] word_out;
  logic              block_end;
  modport source (output valid, output dest_index, output word_out, output block_end,
                  input ready);
  modport sink (input valid, input dest_index, input word_out, input block_end,
                output ready);
endinterface
`default_nettype wire

// File: hdl/t4p_cfg_regs.sv
// APB register file holding the extents and swap flags.
`default_nettype none
module t4p_cfg_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [t4p_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [t4p_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [t4p_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                    pready,
  output t4p_pkg::cfg_t                           cfg_o
);
  import t4p_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = paddr[APB_ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_EXTENT_A:   cfg_d.extent_a   = pwdata[EXT_REG_W-1:0];
        REG_EXTENT_B:   cfg_d.extent_b   = pwdata[EXT_REG_W-1:0];
        REG_EXTENT_C:   cfg_d.extent_c   = pwdata[EXT_REG_W-1:0];
        REG_EXTENT_D:   cfg_d.extent_d   = pwdata[EXT_REG_W-1:0];
        REG_SWAP_12:    cfg_d.swap_12    = pwdata[0];
        REG_SWAP_34:    cfg_d.swap_34    = pwdata[0];
        REG_SWAP_PAIRS: cfg_d.swap_pairs = pwdata[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_EXTENT_A:   prdata = APB_DATA_W'(cfg_q.extent_a);
      REG_EXTENT_B:   prdata = APB_DATA_W'(cfg_q.extent_b);
      REG_EXTENT_C:   prdata = APB_DATA_W'(cfg_q.extent_c);
      REG_EXTENT_D:   prdata = APB_DATA_W'(cfg_q.extent_d);
      REG_SWAP_12:    prdata = APB_DATA_W'(cfg_q.swap_12);
      REG_SWAP_34:    prdata = APB_DATA_W'(cfg_q.swap_34);
      REG_SWAP_PAIRS: prdata = APB_DATA_W'(cfg_q.swap_pairs);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.extent_a   <= EXT_REG_W'(1);
      cfg_q.extent_b   <= EXT_REG_W'(1);
      cfg_q.extent_c   <= EXT_REG_W'(1);
      cfg_q.extent_d   <= EXT_REG_W'(1);
      cfg_q.swap_12    <= 1'b0;
      cfg_q.swap_34    <= 1'b0;
      cfg_q.swap_pairs <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

// File: hdl/t4p_ctrl.sv
// Controller sequencing load, multiply-accumulate steps and result hand-off.
`default_nettype none
module t4p_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire t4p_pkg::dp_status_t status_i,
  output t4p_pkg::ctrl_cmd_t       cmd_o
);
  import t4p_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_CALC = 1'b1;
  localparam step_t LAST_STEP = 2'd3;

  logic  state_q, state_d;
  step_t step_q, step_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o.load = 1'b0;
    cmd_o.mac  = 1'b0;
    cmd_o.emit = 1'b0;
    cmd_o.step = step_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = 2'd1;
          state_d    = S_CALC;
        end
      end
      S_CALC: begin
        if (step_q != LAST_STEP) begin
          cmd_o.mac = 1'b1;
          step_d    = step_q + 2'd1;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          step_d     = '0;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule
`default_nettype wire

// File: hdl/t4p_dpath.sv
// Datapath: coordinate counters, shared multiply-add unit and output register.
`default_nettype none
module t4p_dpath #(
  parameter int unsigned MAX_EXTENT = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire t4p_pkg::cfg_t                 cfg_i,
  input  wire t4p_pkg::ctrl_cmd_t            cmd_i,
  output t4p_pkg::dp_status_t                status_o,
  input  wire logic [t4p_pkg::WORD_W-1:0]    word_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [t4p_pkg::DEST_W-1:0]    dest_index_o,
  output logic      [t4p_pkg::WORD_W-1:0]    word_out_o,
  output logic                               block_end_o
);
  import t4p_pkg::*;

  localparam int unsigned ExtW = $clog2(MAX_EXTENT + 1);
  localparam int unsigned PosW = (MAX_EXTENT > 1) ? $clog2(MAX_EXTENT) : 1;

  typedef logic [ExtW-1:0] ext_t;
  typedef logic [PosW-1:0] pos_t;

  function automatic ext_t clamp_ext(logic [EXT_REG_W-1:0] v);
    if (v == '0) begin
      return ext_t'(1);
    end else if (int'(v) > int'(MAX_EXTENT)) begin
      return ext_t'(MAX_EXTENT);
    end
    return ext_t'(v);
  endfunction

  function automatic logic on_last(pos_t p, ext_t e);
    return (int'(p) + 1) >= int'(e);
  endfunction

  ext_t ext_a, ext_b, ext_c, ext_d, ext_sel;
  pos_t pos_a_q, pos_b_q, pos_c_q, pos_d_q;
  pos_t pos_a_d, pos_b_d, pos_c_d, pos_d_d, pos_sel;
  logic la, lb, lc, ld, last;
  order_sel_t sel;
  axis_t axis;
  logic [DEST_W-1:0] acc_q, acc_d, mac_res, prod;
  logic [WORD_W-1:0] word_q;
  logic              out_valid_q, out_valid_d;
  logic [DEST_W-1:0] dest_q;
  logic [WORD_W-1:0] wout_q;
  logic              end_q;

  assign ext_a = clamp_ext(cfg_i.extent_a);
  assign ext_b = clamp_ext(cfg_i.extent_b);
  assign ext_c = clamp_ext(cfg_i.extent_c);
  assign ext_d = clamp_ext(cfg_i.extent_d);

  assign la   = on_last(pos_a_q, ext_a);
  assign lb   = on_last(pos_b_q, ext_b);
  assign lc   = on_last(pos_c_q, ext_c);
  assign ld   = on_last(pos_d_q, ext_d);
  assign last = la & lb & lc & ld;

  assign sel  = {cfg_i.swap_pairs, cfg_i.swap_12, cfg_i.swap_34};
  assign axis = order_axis(sel, cmd_i.step);

  always_comb begin
    case (axis)
      AX_A:    begin pos_sel = pos_a_q; ext_sel = ext_a; end
      AX_B:    begin pos_sel = pos_b_q; ext_sel = ext_b; end
      AX_C:    begin pos_sel = pos_c_q; ext_sel = ext_c; end
      AX_D:    begin pos_sel = pos_d_q; ext_sel = ext_d; end
      default: begin pos_sel = pos_a_q; ext_sel = ext_a; end
    endcase
  end

  assign prod    = DEST_W'(acc_q * DEST_W'(ext_sel));
  assign mac_res = DEST_W'(prod + DEST_W'(pos_sel));

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.load) begin
      acc_d = DEST_W'(pos_sel);
    end else if (cmd_i.mac) begin
      acc_d = mac_res;
    end
  end

  always_comb begin
    pos_a_d = pos_a_q;
    pos_b_d = pos_b_q;
    pos_c_d = pos_c_q;
    pos_d_d = pos_d_q;
    if (cmd_i.emit) begin
      if (!ld) begin
        pos_d_d = pos_d_q + pos_t'(1);
      end else begin
        pos_d_d = '0;
        if (!lc) begin
          pos_c_d = pos_c_q + pos_t'(1);
        end else begin
          pos_c_d = '0;
          if (!lb) begin
            pos_b_d = pos_b_q + pos_t'(1);
          end else begin
            pos_b_d = '0;
            pos_a_d = la ? '0 : pos_a_q + pos_t'(1);
          end
        end
      end
    end
  end

  assign status_o.out_free = ~out_valid_q | out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_a_q     <= '0;
      pos_b_q     <= '0;
      pos_c_q     <= '0;
      pos_d_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_a_q     <= pos_a_d;
      pos_b_q     <= pos_b_d;
      pos_c_q     <= pos_c_d;
      pos_d_q     <= pos_d_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.load) begin
      word_q <= word_i;
    end
    if (cmd_i.emit) begin
      dest_q <= mac_res;
      wout_q <= word_q;
      end_q  <= last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign dest_index_o = dest_q;
  assign word_out_o   = wout_q;
  assign block_end_o  = end_q;

endmodule
`default_nettype wire

// File: hdl/tensor4_permute_scatter.sv
// Top level of the four-index block reorder: registers, controller and datapath.
// The accepted word is loaded, two multiply-add steps follow and the emit step writes
// the output register once it is free. Words are taken one at a time, with three passes
// through one shared 16-bit multiply-add unit per destination index.
// A finished word waits in the output register while the next word is taken.
// Reset (asynchronous, active low): extents 1, swap flags 0, counters 0, no word held.
`default_nettype none
module tensor4_permute_scatter #(
  parameter int unsigned MAX_EXTENT = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [t4p_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [t4p_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [t4p_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready,
  t4p_in_if.sink                              in_i,
  t4p_out_if.source                           out_o
);
  import t4p_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  t4p_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  t4p_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  t4p_dpath #(
    .MAX_EXTENT (MAX_EXTENT)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .status_o     (status),
    .word_i       (in_i.word),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .dest_index_o (out_o.dest_index),
    .word_out_o   (out_o.word_out),
    .block_end_o  (out_o.block_end)
  );

endmodule
`default_nettype wire
